// File: rtl/rle_texture_decoder_rotated_macros.svh
// assertion macros for the rle texture decoder, used by rtd_back
// expects clk and arst_n in the scope of each use
`ifndef RLE_TEXTURE_DECODER_ROTATED_MACROS_SVH
`define RLE_TEXTURE_DECODER_ROTATED_MACROS_SVH

// clocked check, off while reset is asserted
`define RTD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rtd assertion failed");

// same, with a caller message
`define RTD_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

// File: rtl/rtd_pkg.sv
// shared types and constants of the rle texture decoder
// no dependencies
package rtd_pkg;

	localparam logic [7:0] RUN_MARK     = 8'hC0;
	localparam logic [5:0] RUN_MASK     = 6'h3F;
	localparam logic [7:0] HEADER_RESET = 8'd128;

	localparam int IMG_WIDTH_DEF  = 128;
	localparam int IMG_HEIGHT_DEF = 128;
	localparam int CMD_DEPTH      = 4;

	localparam logic REG_HEADER_SKIP = 1'b0;

	// one decoded command: a value repeated count times
	typedef struct packed {
		logic       restart;
		logic [7:0] value;
		logic [5:0] count;
	} cmd_t;

endpackage

// File: rtl/rtd_front.sv
// byte front end: header skip, run marker parsing, command generation
// depends on rtd_pkg
module rtd_front import rtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       restart,
	input  logic [7:0] header_skip,
	output logic       cmd_wr,
	output cmd_t       cmd
);

	logic [7:0] header_seen_q;
	logic       run_pending_q;
	logic [5:0] run_count_q;

	logic [7:0] hs;
	logic       rp;

	always_comb begin
		hs = restart ? 8'd0 : header_seen_q;
		rp = restart ? 1'b0 : run_pending_q;
	end

	always_comb begin
		cmd.restart = restart;
		cmd.value   = data_byte;
		cmd.count   = 6'd0;
		cmd_wr      = accept && restart;
		priority if (hs < header_skip) begin
			cmd.count = 6'd0;
		end else if (rp) begin
			cmd.count = restart ? 6'd0 : run_count_q;
			cmd_wr    = accept;
		end else if (data_byte >= RUN_MARK) begin
			cmd.count = 6'd0;
		end else begin
			cmd.count = 6'd1;
			cmd_wr    = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_seen_q <= 8'd0;
			run_pending_q <= 1'b0;
			run_count_q   <= 6'd0;
		end else if (accept) begin
			header_seen_q <= hs;
			run_pending_q <= rp;
			if (restart) begin
				run_count_q <= 6'd0;
			end
			priority if (hs < header_skip) begin
				header_seen_q <= hs + 8'd1;
			end else if (rp) begin
				run_pending_q <= 1'b0;
			end else if (data_byte >= RUN_MARK) begin
				run_pending_q <= 1'b1;
				run_count_q   <= data_byte[5:0] & RUN_MASK;
			end
		end
	end

endmodule

// File: rtl/rtd_cmd_fifo.sv
// short command queue between the front end and the pixel back end
// depends on rtd_pkg
module rtd_cmd_fifo import rtd_pkg::*; #(
	parameter int DEPTH = CMD_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	input  logic rd,
	output cmd_t rdata,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	logic do_wr;
	logic do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/rtd_back.sv
// pixel back end: expands commands into pixels with rotated store addresses
// depends on rtd_pkg and the assertion macro header
`include "rle_texture_decoder_rotated_macros.svh"

module rtd_back import rtd_pkg::*; #(
	parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_empty,
	output logic        cmd_pop,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  pixel_value,
	output logic [13:0] pixel_address,
	output logic        last_of_run,
	output logic        image_done
);

	localparam int TOTAL_N = IMG_WIDTH * IMG_HEIGHT;
	localparam int AW = $clog2(TOTAL_N);
	localparam int DW = $clog2(TOTAL_N + 1);
	localparam int CW = $clog2(IMG_WIDTH + 1);
	localparam int RW = $clog2(IMG_HEIGHT);
	localparam logic [DW-1:0] TOTAL    = DW'(TOTAL_N);
	localparam logic [AW-1:0] TOP_BASE = AW'((IMG_HEIGHT - 1) * IMG_WIDTH);
	localparam logic [AW-1:0] STEP     = AW'(IMG_WIDTH);
	localparam logic [RW-1:0] TOP_ROW  = RW'(IMG_HEIGHT - 1);

	logic          cur_valid_q;
	logic [7:0]    cur_value_q;
	logic [5:0]    cur_cnt_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] row_base_q;
	logic [DW-1:0] done_q;

	logic          out_valid_q;
	logic [7:0]    value_q;
	logic [13:0]   addr_q;
	logic          last_q;
	logic          image_done_q;

	logic          emit;
	logic          last_pix;
	logic          fin;
	logic [DW-1:0] done_inc;
	logic [DW-1:0] done_next;
	logic          full_next;
	logic [AW-1:0] addr_sum;
	logic [AW+13:0] addr_ext;

	assign emit      = cur_valid_q && (!out_valid_q || pop);
	assign done_inc  = done_q + 1'b1;
	assign last_pix  = (done_inc == TOTAL);
	assign fin       = emit && ((cur_cnt_q == 6'd1) || last_pix);
	assign done_next = emit ? done_inc : done_q;
	assign full_next = (done_next >= TOTAL);
	assign cmd_pop   = !cmd_empty && (!cur_valid_q || fin);

	// column may be one wider than needed; it is cast to the address width for the sum
	assign addr_sum = AW'(col_q) + row_base_q;
	assign addr_ext = {14'd0, addr_sum};

	assign empty         = !out_valid_q;
	assign pixel_value   = value_q;
	assign pixel_address = addr_q;
	assign last_of_run   = last_q;
	assign image_done    = image_done_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q      <= cur_value_q;
			addr_q       <= addr_ext[13:0];
			last_q       <= (cur_cnt_q == 6'd1) || last_pix;
			image_done_q <= last_pix;
		end
		if (cmd_pop) begin
			cur_value_q <= cmd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_valid_q <= 1'b0;
			cur_cnt_q   <= 6'd0;
			col_q       <= '0;
			row_q       <= TOP_ROW;
			row_base_q  <= TOP_BASE;
			done_q      <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			// a zero count, or a full image without restart, leaves nothing to expand
			if (cmd_pop) begin
				cur_valid_q <= (cmd.count != 6'd0) && (cmd.restart || !full_next);
				cur_cnt_q   <= cmd.count;
			end else if (fin) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				cur_cnt_q <= cur_cnt_q - 6'd1;
			end

			// restart of the next command wins over the pixel just sent
			if (cmd_pop && cmd.restart) begin
				col_q      <= '0;
				row_q      <= TOP_ROW;
				row_base_q <= TOP_BASE;
				done_q     <= '0;
			end else if (emit) begin
				done_q <= done_inc;
				if (row_q == '0) begin
					row_q      <= TOP_ROW;
					row_base_q <= TOP_BASE;
					col_q      <= col_q + 1'b1;
				end else begin
					row_q      <= row_q - 1'b1;
					row_base_q <= row_base_q - STEP;
				end
			end
		end
	end

	`RTD_ASSERT(a_done_is_last, out_valid_q && image_done_q |-> last_q)
	`RTD_ASSERT_MSG(a_no_pixel_when_full, done_q >= TOTAL |-> !emit, "pixel past full image")
	`RTD_ASSERT_MSG(a_active_cnt, cur_valid_q |-> cur_cnt_q != 6'd0, "active run with zero count")
	`RTD_ASSERT(a_restart_clears, cmd_pop && cmd.restart |=> done_q == '0 && row_q == TOP_ROW)

endmodule

// File: rtl/rle_texture_decoder_rotated.sv
// top level of the rle texture decoder with rotated store addressing
// depends on rtd_pkg, rtd_front, rtd_cmd_fifo, rtd_back
//
// Usage: encoded file bytes enter on the push/full queue port, one beat per
// byte, with restart set on the first byte of each file. Decoded pixels leave
// on the empty/pop queue port, one beat per pixel, carrying the colour index,
// the store address (column plus row times width, row falling first) and
// last-of-run and image-done flags.
// The front end takes one byte per cycle while the queue is not full and
// writes a command into a four-entry queue; header bytes and run markers
// leave no command unless they carry restart.
// The back end turns a command into pixels at one per cycle while the
// receiver keeps up, and pulls the next command in the cycle that sends
// the last pixel of the current one. A byte passes through a queue slot,
// the current-command registers and the output register before its first
// pixel shows on the result ports.
// When the receiver stalls, the output register holds its beat, the back end
// stops, the queue fills and then full rises. After reset all counters are
// cleared, the row starts at the top row and header_skip reads 128.
// header_skip is written over the APB port at byte address 0.
module rle_texture_decoder_rotated import rtd_pkg::*; #(
	parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  pixel_value,
	output logic [13:0] pixel_address,
	output logic        last_of_run,
	output logic        image_done
);

	logic [7:0] header_skip_q;
	logic       accept;
	logic       cmd_wr;
	cmd_t       cmd_in;
	cmd_t       cmd_out;
	logic       cmd_empty;
	logic       cmd_pop;

	assign pready = 1'b1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_skip_q <= HEADER_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_HEADER_SKIP)) begin
			header_skip_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_HEADER_SKIP) ? {24'd0, header_skip_q} : 32'd0;

	rtd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.restart     (restart),
		.header_skip (header_skip_q),
		.cmd_wr      (cmd_wr),
		.cmd         (cmd_in)
	);

	rtd_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd_in),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.full   (full),
		.empty  (cmd_empty)
	);

	rtd_back #(
		.IMG_WIDTH  (IMG_WIDTH),
		.IMG_HEIGHT (IMG_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_out),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.pop           (pop),
		.empty         (empty),
		.pixel_value   (pixel_value),
		.pixel_address (pixel_address),
		.last_of_run   (last_of_run),
		.image_done    (image_done)
	);

endmodule
